// ----- design/vertex_weld_normal_accumulator_core_assert.svh -----
// ---------------------------------------------------------------------------
// Vertex weld accumulator assertion macros
// Clocked property wrappers used by the accumulator core.
// ---------------------------------------------------------------------------
`ifndef VERTEX_WELD_NORMAL_ACCUMULATOR_CORE_ASSERT_SVH
`define VERTEX_WELD_NORMAL_ACCUMULATOR_CORE_ASSERT_SVH

// check outside reset
`define VWNA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check at every edge, reset included
`define VWNA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/vwna_pkg.sv -----
// ---------------------------------------------------------------------------
// Vertex weld accumulator package
// Table size, field widths, mode codes and transaction types.
// ---------------------------------------------------------------------------
package vwna_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int TOL_W        = 17;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_READ  = 2'd2
  } vwna_mode_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [7:0]         read_index;
  } vwna_in_t;

  typedef struct packed {
    logic [7:0]         vertex_index;
    logic               is_new;
    logic               table_full;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] entry_z;
    logic signed [23:0] sum_x;
    logic signed [23:0] sum_y;
    logic signed [23:0] sum_z;
  } vwna_out_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [7:0]         read_index;
    logic               hit;
    logic               is_new;
    logic [IDX_W-1:0]   index;
    logic signed [23:0] sum_x;
    logic signed [23:0] sum_y;
    logic signed [23:0] sum_z;
  } vwna_tok_t;

endpackage

// ----- design/vwna_cell.sv -----
// ---------------------------------------------------------------------------
// Vertex weld table cell
// Holds one table entry; compares, merges, appends or reads for the
// transaction passing through, then hands it to the next cell.
// ---------------------------------------------------------------------------
module vwna_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [vwna_pkg::IDX_W-1:0]  cell_index,
  input  logic [vwna_pkg::CNT_W-1:0]  count,
  input  logic [vwna_pkg::TOL_W-1:0]  tolerance,
  input  vwna_pkg::vwna_tok_t         tok_in,
  output vwna_pkg::vwna_tok_t         tok_out
);

  function automatic logic axis_close(logic [31:0] a, logic [31:0] b,
                                      logic [vwna_pkg::TOL_W-1:0] tol);
    logic [32:0] d;
    logic [32:0] mag;
    d   = {a[31], a} - {b[31], b};
    mag = d[32] ? (~d + 33'd1) : d;
    return mag < 33'(tol);
  endfunction

  function automatic logic [23:0] sat_add(logic [23:0] s, logic [15:0] n);
    logic [24:0] t;
    t = {s[23], s} + {{9{n[15]}}, n};
    if (t[24] != t[23]) begin
      return t[24] ? 24'h800000 : 24'h7fffff;
    end
    return t[23:0];
  endfunction

  logic signed [31:0] ent_x, ent_y, ent_z;
  logic signed [23:0] ent_sx, ent_sy, ent_sz;

  vwna_pkg::vwna_tok_t tok_next;
  logic               live;
  logic               close;
  logic               merge;
  logic               append;
  logic               read_hit;
  logic [23:0]        new_sx, new_sy, new_sz;

  assign live   = vwna_pkg::CNT_W'(cell_index) < count;
  assign close  = axis_close(ent_x, tok_in.pos_x, tolerance) &&
                  axis_close(ent_y, tok_in.pos_y, tolerance) &&
                  axis_close(ent_z, tok_in.pos_z, tolerance);
  assign merge  = tok_in.valid && (tok_in.mode == vwna_pkg::MODE_ADD) && !tok_in.hit &&
                  live && close;
  assign append = tok_in.valid && (tok_in.mode == vwna_pkg::MODE_ADD) && !tok_in.hit &&
                  (vwna_pkg::CNT_W'(cell_index) == count);
  assign read_hit = tok_in.valid && (tok_in.mode == vwna_pkg::MODE_READ) && live &&
                    (32'(cell_index) == 32'(tok_in.read_index));

  assign new_sx = sat_add(ent_sx, tok_in.norm_x);
  assign new_sy = sat_add(ent_sy, tok_in.norm_y);
  assign new_sz = sat_add(ent_sz, tok_in.norm_z);

  always_comb begin
    tok_next = tok_in;
    priority if (merge) begin
      tok_next.hit   = 1'b1;
      tok_next.index = cell_index;
      tok_next.pos_x = ent_x;
      tok_next.pos_y = ent_y;
      tok_next.pos_z = ent_z;
      tok_next.sum_x = new_sx;
      tok_next.sum_y = new_sy;
      tok_next.sum_z = new_sz;
    end else if (append) begin
      tok_next.hit    = 1'b1;
      tok_next.is_new = 1'b1;
      tok_next.index  = cell_index;
      tok_next.sum_x  = 24'(tok_in.norm_x);
      tok_next.sum_y  = 24'(tok_in.norm_y);
      tok_next.sum_z  = 24'(tok_in.norm_z);
    end else if (read_hit) begin
      tok_next.hit   = 1'b1;
      tok_next.pos_x = ent_x;
      tok_next.pos_y = ent_y;
      tok_next.pos_z = ent_z;
      tok_next.sum_x = ent_sx;
      tok_next.sum_y = ent_sy;
      tok_next.sum_z = ent_sz;
    end else begin
      tok_next = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
      if (merge) begin
        ent_sx <= new_sx;
        ent_sy <= new_sy;
        ent_sz <= new_sz;
      end else if (append) begin
        ent_x  <= tok_in.pos_x;
        ent_y  <= tok_in.pos_y;
        ent_z  <= tok_in.pos_z;
        ent_sx <= 24'(tok_in.norm_x);
        ent_sy <= 24'(tok_in.norm_y);
        ent_sz <= 24'(tok_in.norm_z);
      end
    end
  end

endmodule

// ----- design/vertex_weld_normal_accumulator_core.sv -----
// ---------------------------------------------------------------------------
// Vertex weld normal accumulator
// Table of welded vertices held in a row of cells; adds merge normals into a
// matching entry or append a new one, reads return an entry, clear empties.
// ---------------------------------------------------------------------------
//  channel   handshake                  payload
//  item      item_valid / item_ready    item   (vwna_in_t)
//  result    result_valid / result_ready result (vwna_out_t)
//  config    cfg_we                     cfg_wdata (match tolerance)
//
// An item walks the cell row one cell per cycle unless the row is frozen;
// result_valid rises when it leaves the last cell and busy drops in that same
// cycle, so the next item is taken only after the previous one has retired.
// Reset empties the table and sets the tolerance to 1; no clearing pass.
// A held result with result_ready low freezes the cell row once an item is in the last cell.
// ---------------------------------------------------------------------------
module vertex_weld_normal_accumulator_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  vwna_pkg::vwna_in_t         item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output vwna_pkg::vwna_out_t        result,
  input  logic                       cfg_we,
  input  logic [vwna_pkg::TOL_W-1:0] cfg_wdata
);

  localparam int N = vwna_pkg::MAX_VERTICES;

  vwna_pkg::vwna_tok_t chain [0:N];
  vwna_pkg::vwna_tok_t head;
  vwna_pkg::vwna_tok_t tail;
  vwna_pkg::vwna_out_t res_next;

  logic [vwna_pkg::TOL_W-1:0] tolerance;
  logic [vwna_pkg::CNT_W-1:0] count;
  logic [vwna_pkg::CNT_W-1:0] count_next;
  logic                       busy;
  logic                       accept;
  logic                       advance;
  logic                       retire;

  assign item_ready = !busy;
  assign accept     = item_valid && item_ready;
  assign tail       = chain[N];
  assign advance    = !(tail.valid && result_valid && !result_ready);
  assign retire     = tail.valid && advance;
  assign chain[0]   = head;

  for (genvar g = 0; g < N; g++) begin : g_cell
    vwna_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .cell_index (vwna_pkg::IDX_W'(g)),
      .count      (count),
      .tolerance  (tolerance),
      .tok_in     (chain[g]),
      .tok_out    (chain[g+1])
    );
  end

  always_comb begin
    res_next   = '0;
    count_next = count;
    unique case (tail.mode)
      vwna_pkg::MODE_CLEAR: begin
        count_next = '0;
      end
      vwna_pkg::MODE_READ: begin
        res_next.vertex_index = tail.read_index;
        if (tail.hit) begin
          res_next.entry_x = tail.pos_x;
          res_next.entry_y = tail.pos_y;
          res_next.entry_z = tail.pos_z;
          res_next.sum_x   = tail.sum_x;
          res_next.sum_y   = tail.sum_y;
          res_next.sum_z   = tail.sum_z;
        end
      end
      vwna_pkg::MODE_ADD: begin
        if (tail.hit) begin
          res_next.vertex_index = 8'(tail.index);
          res_next.is_new       = tail.is_new;
          res_next.entry_x      = tail.pos_x;
          res_next.entry_y      = tail.pos_y;
          res_next.entry_z      = tail.pos_z;
          res_next.sum_x        = tail.sum_x;
          res_next.sum_y        = tail.sum_y;
          res_next.sum_z        = tail.sum_z;
          if (tail.is_new) begin
            count_next = count + vwna_pkg::CNT_W'(1);
          end
        end else begin
          res_next.table_full = 1'b1;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance    <= vwna_pkg::TOL_W'(1);
      count        <= '0;
      busy         <= 1'b0;
      head.valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tolerance <= cfg_wdata;
      end
      if (accept) begin
        head.valid      <= 1'b1;
        head.mode       <= item.mode;
        head.pos_x      <= item.pos_x;
        head.pos_y      <= item.pos_y;
        head.pos_z      <= item.pos_z;
        head.norm_x     <= item.norm_x;
        head.norm_y     <= item.norm_y;
        head.norm_z     <= item.norm_z;
        head.read_index <= item.read_index;
        head.hit        <= 1'b0;
        head.is_new     <= 1'b0;
        head.index      <= '0;
        head.sum_x      <= '0;
        head.sum_y      <= '0;
        head.sum_z      <= '0;
        busy            <= 1'b1;
      end else if (advance) begin
        head.valid <= 1'b0;
      end
      if (retire) begin
        result       <= res_next;
        result_valid <= 1'b1;
        count        <= count_next;
        busy         <= 1'b0;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `include "vertex_weld_normal_accumulator_core_assert.svh"

  `VWNA_ASSERT(a_idle_chain_empty, !busy |-> !tail.valid, "transaction in cell row while idle")
  `VWNA_ASSERT(a_accept_busy, accept |=> busy, "accepted transaction did not mark busy")
  `VWNA_ASSERT(a_count_bound, count <= vwna_pkg::CNT_W'(N), "entry count beyond table size")
  `VWNA_ASSERT(a_retire_result, retire |=> (result_valid && !busy), "retired transaction lost")
  `VWNA_ASSERT_RST(a_reset_clear, rst |=> (!busy && !result_valid), "control not cleared by reset")

endmodule
